/* rtl/bda_pkg.sv */
package bda_pkg;

    localparam int NUM_BUTTONS = 4;
    localparam int TIME_BITS   = 32;
    localparam int NOW_BITS    = 32;
    localparam int IVL_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // register indexes on the config channel
    localparam t_cfg_idx CFG_SETTLE_IVL = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_REPEAT_IVL = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_REPEAT_EN  = t_cfg_idx'(2);

    localparam logic [IVL_BITS-1:0] SETTLE_RST = IVL_BITS'(50);
    localparam logic [IVL_BITS-1:0] REPEAT_RST = IVL_BITS'(250);

    typedef struct packed {
        logic [IVL_BITS-1:0] settle_ivl;
        logic [IVL_BITS-1:0] repeat_ivl;
    } t_timing;

    typedef struct packed {
        logic evt;
        logic level;
    } t_btn_evt;

endpackage

/* rtl/bda_if.sv */
interface bda_in_if
    import bda_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] raw_lines;
    logic [NOW_BITS-1:0]    now_ms;

    modport source (output valid, output raw_lines, output now_ms, input ready);
    modport sink   (input valid, input raw_lines, input now_ms, output ready);
endinterface

interface bda_out_if
    import bda_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [NUM_BUTTONS-1:0] pressed_mask;
    logic [NUM_BUTTONS-1:0] released_mask;
    logic                   any_event;

    modport source (output valid, output pressed_mask, output released_mask,
                    output any_event, input ready);
    modport sink   (input valid, input pressed_mask, input released_mask,
                    input any_event, output ready);
endinterface

interface bda_cfg_if
    import bda_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/bda_button.sv */
module bda_button
    import bda_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_pressed,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_timing              i_timing,
    input  logic                 i_rpt_en,
    output t_btn_evt             o_evt
);

    logic                 r_last, n_last;
    logic                 r_unst, n_unst;
    logic                 r_lvl,  n_lvl;
    logic [TIME_BITS-1:0] r_mark, n_mark;
    logic [TIME_BITS-1:0] s_elapsed;
    logic                 s_settled, s_rpt_due, s_evt;

    // wraps modulo 2^TIME_BITS
    assign s_elapsed = i_now - r_mark;
    assign s_settled = s_elapsed > TIME_BITS'(i_timing.settle_ivl);
    assign s_rpt_due = s_elapsed > TIME_BITS'(i_timing.repeat_ivl);

    always_comb begin
        n_last = r_last;
        n_unst = r_unst;
        n_lvl  = r_lvl;
        n_mark = r_mark;
        s_evt  = 1'b0;
        if (r_last != i_pressed) begin
            n_last = i_pressed;
            n_mark = i_now;
            n_unst = 1'b1;
        end else if (r_unst) begin
            if (s_settled) begin
                n_unst = 1'b0;
                n_mark = i_now;
                if (r_lvl != i_pressed) begin
                    n_lvl = i_pressed;
                    s_evt = 1'b1;
                end
            end
        end else if (r_lvl && i_rpt_en) begin
            if (s_rpt_due) begin
                n_mark = i_now;
                s_evt  = 1'b1;
            end
        end
    end

    assign o_evt.evt   = s_evt;
    assign o_evt.level = n_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
            r_unst <= 1'b0;
            r_lvl  <= 1'b0;
            r_mark <= '0;
        end else if (i_en) begin
            r_last <= n_last;
            r_unst <= n_unst;
            r_lvl  <= n_lvl;
            r_mark <= n_mark;
        end
    end

endmodule

/* rtl/button_debounce_autorepeat_top.sv */
// Button debouncer with auto-repeat for NUM_BUTTONS active-low lines.
//
// i_in  : one poll per request: raw_lines (low = pressed) and now_ms, a
//         free-running millisecond timestamp that wraps.
// o_out : exactly one result per poll: pressed_mask, released_mask and
//         any_event (debounced change or repeated press this poll).
// i_cfg : register writes (0 settle interval, 1 repeat interval,
//         2 repeat enable mask); always ready, unknown indexes are dropped.
//         Write only while no poll is in flight.
//
// A taken poll is held in the input register, evaluated into the result
// register and offered on o_out from there until it is handed off.
// Throughput: one poll per cycle while o_out takes results, set by the
// single evaluation stage (one subtract and two compares per button, all buttons in parallel).
// When o_out stalls the result register holds, one more poll can wait in
// the input register, and only then does i_in.ready drop.
// Reset clears all button state, empties both registers and loads the
// default intervals (50 ms settle, 250 ms repeat, repeat disabled).
module button_debounce_autorepeat_top
    import bda_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bda_in_if.sink    i_in,
    bda_out_if.source o_out,
    bda_cfg_if.sink   i_cfg
);

    // configuration
    t_timing                r_timing;
    logic [NUM_BUTTONS-1:0] r_rpt_en;

    // input stage
    logic                   r_in_valid;
    logic [NUM_BUTTONS-1:0] r_in_raw;
    logic [TIME_BITS-1:0]   r_in_now;

    // result stage
    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_pressed, n_pressed;
    logic [NUM_BUTTONS-1:0] r_released, n_released;
    logic                   r_any;

    logic     s_fire;
    logic     s_in_take;
    t_btn_evt s_evt [NUM_BUTTONS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.settle_ivl <= SETTLE_RST;
            r_timing.repeat_ivl <= REPEAT_RST;
            r_rpt_en            <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_SETTLE_IVL: r_timing.settle_ivl <= IVL_BITS'(i_cfg.data);
                CFG_REPEAT_IVL: r_timing.repeat_ivl <= IVL_BITS'(i_cfg.data);
                CFG_REPEAT_EN:  r_rpt_en <= i_cfg.data[NUM_BUTTONS-1:0];
                default: ;
            endcase
        end
    end

    // the held poll moves on when the result slot is free or being emptied
    assign s_fire      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || s_fire;
    assign s_in_take   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= s_in_take || (r_in_valid && !s_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_take) begin
            r_in_raw <= i_in.raw_lines;
            r_in_now <= i_in.now_ms[TIME_BITS-1:0];
        end
    end

    // one lane per button, state advances only when a poll is evaluated
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
        bda_button u_btn (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (s_fire),
            .i_pressed (~r_in_raw[g]),
            .i_now     (r_in_now),
            .i_timing  (r_timing),
            .i_rpt_en  (r_rpt_en[g]),
            .o_evt     (s_evt[g])
        );

        assign n_pressed[g]  = s_evt[g].evt &&  s_evt[g].level;
        assign n_released[g] = s_evt[g].evt && !s_evt[g].level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_any      <= |(n_pressed | n_released);
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pressed_mask  = r_pressed;
    assign o_out.released_mask = r_released;
    assign o_out.any_event     = r_any;

    // a button never reports press and release in the same poll
    a_no_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_pressed & r_released) == '0))
        else $error("press and release on one button");

    // an evaluated poll always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> r_out_valid)
        else $error("evaluated poll lost");

    // a new request with a poll held requires that poll to move on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_in_take && r_in_valid) |-> s_fire)
        else $error("input register overrun");

    // a stalled result is not overwritten
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !s_fire)
        else $error("stalled result overwritten");

endmodule
